FILE: rtl/sbd_pkg.sv
// ----------------------------------------------------------------------------
// Sum-preserving bin downsampler package
// Widths, register indexes and the command and status bundles shared by
// the controller, the datapath and the top level.
// ----------------------------------------------------------------------------
package sbd_pkg;

  localparam int unsigned PeriodW  = 16;
  localparam int unsigned PhaseW   = 17;
  localparam int unsigned SampleW  = 16;
  localparam int unsigned BinW     = 32;
  localparam int unsigned IndexW   = 16;
  localparam int unsigned ProdW    = SampleW + PhaseW;
  localparam int unsigned CfgIdxW  = 8;
  localparam int unsigned DivSteps = ProdW;
  localparam int unsigned DivCntW  = $clog2(DivSteps);

  localparam logic [CfgIdxW-1:0] CfgInPeriod  = CfgIdxW'(0);
  localparam logic [CfgIdxW-1:0] CfgOutPeriod = CfgIdxW'(1);

  typedef struct packed {
    logic accept;
    logic mul;
    logic div_step;
    logic commit_exact;
    logic commit_split;
    logic close;
  } cmd_t;

  typedef struct packed {
    logic phase_eq;
    logic phase_gt;
    logic out_free;
  } sts_t;

endpackage

FILE: rtl/sbd_ctrl.sv
// ----------------------------------------------------------------------------
// Sum-preserving bin downsampler controller
// Sequences one sample through evaluation, the share multiply, the
// bit-serial division and the commit of the output bin.
// ----------------------------------------------------------------------------
module sbd_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  input  sbd_pkg::sts_t sts_i,
  output sbd_pkg::cmd_t cmd_o,
  output logic          busy_o
);

  typedef enum logic [2:0] {
    StIdle,
    StEval,
    StMul,
    StDiv,
    StFin
  } state_e;

  state_e                         state_q;
  logic [sbd_pkg::DivCntW-1:0]    cnt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      cnt_q   <= '0;
    end else begin
      case (state_q)
        StIdle: begin
          if (in_valid_i) state_q <= StEval;
        end
        StEval: begin
          if (sts_i.phase_gt) begin
            state_q <= StMul;
          end else if (!sts_i.phase_eq || sts_i.out_free) begin
            state_q <= StIdle;
          end
        end
        StMul: begin
          cnt_q   <= '0;
          state_q <= StDiv;
        end
        StDiv: begin
          cnt_q <= cnt_q + 1'b1;
          if (cnt_q == sbd_pkg::DivCntW'(sbd_pkg::DivSteps - 1)) state_q <= StFin;
        end
        StFin: begin
          if (sts_i.out_free) state_q <= StIdle;
        end
        default: state_q <= StIdle;
      endcase
    end
  end

  always_comb begin
    cmd_o              = '0;
    cmd_o.accept       = (state_q == StIdle) && in_valid_i;
    cmd_o.mul          = (state_q == StMul);
    cmd_o.div_step     = (state_q == StDiv);
    cmd_o.commit_exact = (state_q == StEval) && sts_i.phase_eq && sts_i.out_free;
    cmd_o.close        = (state_q == StEval) && !sts_i.phase_eq && !sts_i.phase_gt;
    cmd_o.commit_split = (state_q == StFin) && sts_i.out_free;
  end

  assign busy_o = (state_q != StIdle);

endmodule

FILE: rtl/sbd_datapath.sv
// ----------------------------------------------------------------------------
// Sum-preserving bin downsampler datapath
// Holds the period registers, phase, carry and bin count, the share
// multiplier, a restoring divider and the output register.
// ----------------------------------------------------------------------------
module sbd_datapath (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  sbd_pkg::cmd_t                 cmd_i,
  output sbd_pkg::sts_t                 sts_o,
  input  logic                          cfg_we_i,
  input  logic [sbd_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  logic [sbd_pkg::PeriodW-1:0]   cfg_data_i,
  input  logic [sbd_pkg::SampleW-1:0]   sample_value_i,
  input  logic                          last_sample_i,
  input  logic                          out_stall_i,
  output logic                          out_valid_o,
  output logic [sbd_pkg::BinW-1:0]      bin_value_o,
  output logic [sbd_pkg::IndexW-1:0]    bin_index_o,
  output logic                          split_border_o
);

  logic [sbd_pkg::PeriodW-1:0] in_period_q, out_period_q;
  logic [sbd_pkg::PhaseW-1:0]  phase_q;
  logic [sbd_pkg::BinW-1:0]    carry_q;
  logic [sbd_pkg::IndexW-1:0]  bins_q;
  logic                        out_valid_q;
  logic [sbd_pkg::SampleW-1:0] value_q;
  logic                        last_q;
  logic [sbd_pkg::ProdW-1:0]   div_q;
  logic [sbd_pkg::PeriodW-1:0] rem_q;
  logic [sbd_pkg::BinW-1:0]    out_value_q;
  logic [sbd_pkg::IndexW-1:0]  out_index_q;
  logic                        out_split_q;

  logic [sbd_pkg::PhaseW-1:0]  out_period_ext;
  logic [sbd_pkg::PhaseW-1:0]  overshoot;
  logic [sbd_pkg::PeriodW:0]   rem_shift;
  logic [sbd_pkg::PeriodW:0]   rem_sub;
  logic                        rem_ge;
  logic                        round_up;
  logic [sbd_pkg::BinW-1:0]    share;
  logic                        finish;

  assign out_period_ext = {1'b0, out_period_q};
  assign overshoot      = phase_q - out_period_ext;
  assign rem_shift      = {rem_q, div_q[sbd_pkg::ProdW-1]};
  assign rem_sub        = rem_shift - {1'b0, in_period_q};
  assign rem_ge         = (rem_shift >= {1'b0, in_period_q});
  assign round_up       = (rem_q > {1'b0, in_period_q[sbd_pkg::PeriodW-1:1]});
  assign share          = (in_period_q == '0) ? '0
                        : div_q[sbd_pkg::BinW-1:0] + sbd_pkg::BinW'(round_up);
  assign finish         = cmd_i.commit_exact | cmd_i.commit_split | cmd_i.close;

  assign sts_o.phase_eq = (phase_q == out_period_ext);
  assign sts_o.phase_gt = (phase_q > out_period_ext);
  assign sts_o.out_free = !out_valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_period_q  <= sbd_pkg::PeriodW'(1);
      out_period_q <= sbd_pkg::PeriodW'(1);
      phase_q      <= '0;
      carry_q      <= '0;
      bins_q       <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      if (cfg_we_i && cfg_index_i == sbd_pkg::CfgInPeriod) in_period_q <= cfg_data_i;
      if (cfg_we_i && cfg_index_i == sbd_pkg::CfgOutPeriod) out_period_q <= cfg_data_i;

      if (cmd_i.commit_exact || cmd_i.commit_split) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end

      if (cmd_i.accept) begin
        phase_q <= phase_q + {1'b0, in_period_q};
        carry_q <= carry_q + sbd_pkg::BinW'(sample_value_i);
      end

      if (finish && last_q) begin
        phase_q <= '0;
        carry_q <= '0;
        bins_q  <= '0;
      end else if (cmd_i.commit_exact) begin
        phase_q <= '0;
        carry_q <= '0;
        bins_q  <= bins_q + 1'b1;
      end else if (cmd_i.commit_split) begin
        phase_q <= overshoot;
        carry_q <= share;
        bins_q  <= bins_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      value_q <= sample_value_i;
      last_q  <= last_sample_i;
    end
    if (cmd_i.mul) begin
      div_q <= sbd_pkg::ProdW'(value_q) * sbd_pkg::ProdW'(overshoot);
      rem_q <= '0;
    end else if (cmd_i.div_step) begin
      div_q <= {div_q[sbd_pkg::ProdW-2:0], rem_ge};
      rem_q <= rem_ge ? rem_sub[sbd_pkg::PeriodW-1:0] : rem_shift[sbd_pkg::PeriodW-1:0];
    end
    if (cmd_i.commit_exact) begin
      out_value_q <= carry_q;
      out_index_q <= bins_q;
      out_split_q <= 1'b0;
    end else if (cmd_i.commit_split) begin
      out_value_q <= carry_q - share;
      out_index_q <= bins_q;
      out_split_q <= 1'b1;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign bin_value_o    = out_value_q;
  assign bin_index_o    = out_index_q;
  assign split_border_o = out_split_q;

endmodule

FILE: rtl/sum_preserving_bin_downsampler_top.sv
// ----------------------------------------------------------------------------
// Sum-preserving bin downsampler
// Re-bins per-interval counts from in_period to out_period, keeping totals.
// ----------------------------------------------------------------------------
// One sample is taken at a time. A sample that closes no bin or lands
// exactly on a bin border is finished in evaluation; a sample whose border
// falls inside it also goes through the share multiply and the 33-step
// restoring division of the held-back share by in_period. The finished
// bin sits in an output register, so the next sample is taken while it
// waits to be transferred; only a second bin waits for the first to leave.
module sum_preserving_bin_downsampler_top (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [sbd_pkg::SampleW-1:0]   sample_value_i,
  input  logic                          last_sample_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [sbd_pkg::BinW-1:0]      bin_value_o,
  output logic [sbd_pkg::IndexW-1:0]    bin_index_o,
  output logic                          split_border_o,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [sbd_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  logic [sbd_pkg::PeriodW-1:0]   cfg_data_i
);

  sbd_pkg::cmd_t cmd;
  sbd_pkg::sts_t sts;
  logic          busy;

  assign cfg_ready_o = 1'b1;
  assign in_stall_o  = busy;

  sbd_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .sts_i      (sts),
    .cmd_o      (cmd),
    .busy_o     (busy)
  );

  sbd_datapath u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .cfg_we_i       (cfg_valid_i && cfg_ready_o),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .sample_value_i (sample_value_i),
    .last_sample_i  (last_sample_i),
    .out_stall_i    (out_stall_i),
    .out_valid_o    (out_valid_o),
    .bin_value_o    (bin_value_o),
    .bin_index_o    (bin_index_o),
    .split_border_o (split_border_o)
  );

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("block did not go busy after an input transfer");

  a_result_from_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_stall_o))
    else $error("result appeared without a sample in work");

  a_commit_needs_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd.commit_exact || cmd.commit_split) |-> (!out_valid_o || !out_stall_i))
    else $error("bin committed over a stalled result");

endmodule
